// ===== rtl/arl_pkg.sv =====
// -----------------------------------------------------------------------------
// arl_pkg
// Types, widths and the arctangent table shared by the roll angle pipeline.
// -----------------------------------------------------------------------------
package arl_pkg;

   localparam int IN_W         = 16;
   localparam int SQ_W         = 31;            // x*x is at most 2^30
   localparam int SUM_W        = SQ_W + 1;
   localparam int FRAC_PAD     = 8;             // radicand is the sum times 256
   localparam int RAD_W        = SUM_W + FRAC_PAD;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 1;
   localparam int CW           = 23;            // cordic x/y datapath
   localparam int ACC_W        = 32;            // angle accumulator, Q2.30 radians
   localparam int MAG_W        = ACC_W - 1;
   localparam int SCALE_W      = 22;
   localparam int PROD_W       = MAG_W + SCALE_W;
   localparam int DEG_SHIFT    = 38;
   localparam int DEG_W        = 16;
   localparam int TABLE_LEN    = 24;
   localparam int TAB_IDX_W    = $clog2(TABLE_LEN);
   localparam int CORDIC_STEPS = 16;
   localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   localparam logic [SCALE_W-1:0] DEG_SCALE = SCALE_W'(3754936);   // 180/pi * 2^16
   localparam logic [DEG_W-1:0]   DEG_MAX   = DEG_W'(23040);       // 90 degrees * 256

   typedef struct packed {
      logic signed [IN_W-1:0] accel_x;
      logic signed [IN_W-1:0] accel_y;
      logic signed [IN_W-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [DEG_W-1:0] roll_degrees;
      logic signed [IN_W-1:0]  roll_accel;
   } rsp_type;

   // per-sample values carried alongside the datapath
   typedef struct packed {
      logic signed [IN_W-1:0] accel_x;
      logic [IN_W-1:0]        ay;
      logic                   yneg;
      logic                   yzero;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      side_type          side;
   } sqrt_type;

   typedef struct packed {
      logic signed [CW-1:0]    cx;
      logic signed [CW-1:0]    cy;
      logic signed [ACC_W-1:0] acc;
      logic                    rzero;
      side_type                side;
   } cordic_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] t;
      case (idx)
         5'd0:    t = 32'sh3243F6A8;
         5'd1:    t = 32'sh1DAC6705;
         5'd2:    t = 32'sh0FADBAFC;
         5'd3:    t = 32'sh07F56EA6;
         5'd4:    t = 32'sh03FEAB76;
         5'd5:    t = 32'sh01FFD55B;
         5'd6:    t = 32'sh00FFFAAA;
         5'd7:    t = 32'sh007FFF55;
         5'd8:    t = 32'sh003FFFEA;
         5'd9:    t = 32'sh001FFFFD;
         5'd10:   t = 32'sh000FFFFF;
         5'd11:   t = 32'sh0007FFFF;
         5'd12:   t = 32'sh0003FFFF;
         5'd13:   t = 32'sh0001FFFF;
         5'd14:   t = 32'sh0000FFFF;
         5'd15:   t = 32'sh00007FFF;
         5'd16:   t = 32'sh00003FFF;
         5'd17:   t = 32'sh00001FFF;
         5'd18:   t = 32'sh00000FFF;
         5'd19:   t = 32'sh000007FF;
         5'd20:   t = 32'sh000003FF;
         5'd21:   t = 32'sh000001FF;
         5'd22:   t = 32'sh000000FF;
         5'd23:   t = 32'sh0000007F;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/accel_roll_angle.sv =====
// -----------------------------------------------------------------------------
// accel_roll_angle
// Roll angle atan2(y, sqrt(x*x + z*z)) in degrees * 256 from one sample.
// Pipeline: 2 square/sum stages, 20 square-root cells,
// one CORDIC cell per step, 3 scaling stages; every cell stage is a register.
// Throughput: one transaction per cycle while rsp_stall is low.
// Reset clears only the stage valid bits; data registers are not reset.
// -----------------------------------------------------------------------------
module accel_roll_angle (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  arl_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output arl_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   localparam int NR = arl_pkg::ROOT_W;
   localparam int NC = arl_pkg::NUM_STEPS;

   logic                sq_v   [0:NR];
   logic                sq_rdy [0:NR];
   arl_pkg::sqrt_type   sq_d   [0:NR];

   logic                co_v   [0:NC];
   logic                co_rdy [0:NC];
   arl_pkg::cordic_type co_d   [0:NC];

   logic                front_ready;

   assign req_stall = ~front_ready;

   arl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .up_ready  (front_ready),
      .out_valid (sq_v[0]),
      .out_data  (sq_d[0]),
      .dn_ready  (sq_rdy[0])
   );

   for (genvar i = 0; i < NR; i++) begin : g_sqrt
      arl_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[i]),
         .in_data   (sq_d[i]),
         .up_ready  (sq_rdy[i]),
         .out_valid (sq_v[i+1]),
         .out_data  (sq_d[i+1]),
         .dn_ready  (sq_rdy[i+1])
      );
   end

   // start the rotation from (root, |y| * 16)
   always_comb begin
      co_d[0].cx    = arl_pkg::CW'(sq_d[NR].root);
      co_d[0].cy    = arl_pkg::CW'({sq_d[NR].side.ay, 4'b0000});
      co_d[0].acc   = '0;
      co_d[0].rzero = (sq_d[NR].root == '0);
      co_d[0].side  = sq_d[NR].side;
   end
   assign co_v[0]       = sq_v[NR];
   assign sq_rdy[NR]    = co_rdy[0];

   for (genvar i = 0; i < NC; i++) begin : g_cordic
      arl_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (arl_pkg::TAB_IDX_W'(i)),
         .in_valid  (co_v[i]),
         .in_data   (co_d[i]),
         .up_ready  (co_rdy[i]),
         .out_valid (co_v[i+1]),
         .out_data  (co_d[i+1]),
         .dn_ready  (co_rdy[i+1])
      );
   end

   arl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (co_v[NC]),
      .in_data   (co_d[NC]),
      .up_ready  (co_rdy[NC]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .dn_ready  (~rsp_stall)
   );

   // input only backs up when a finished transaction is held at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_deg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.roll_degrees <= 16'sd23040)
                  && (rsp_data.roll_degrees >= -16'sd23040)))
      else $error("roll angle out of range");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      sq_v[NR] |-> (sq_d[NR].rem <= {sq_d[NR].root, 1'b0}))
      else $error("square root remainder too large");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

// ===== rtl/arl_front.sv =====
// -----------------------------------------------------------------------------
// arl_front
// Squares X and Z, sums them and forms the square-root radicand.
// -----------------------------------------------------------------------------
module arl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  arl_pkg::req_type  in_data,
   output logic              up_ready,
   output logic              out_valid,
   output arl_pkg::sqrt_type out_data,
   input  logic              dn_ready
);

   logic                       v1_ff, v1_in, r1;
   logic                       v2_ff, v2_in, r2;
   logic [arl_pkg::SQ_W-1:0]   xx_ff, xx_in, zz_ff, zz_in;
   arl_pkg::side_type          side_ff, side_in;
   arl_pkg::sqrt_type          data_ff, data_in;
   logic signed [2*arl_pkg::IN_W-1:0] xx_full, zz_full;
   logic [arl_pkg::SUM_W-1:0]  sum;

   assign r2 = ~v2_ff | dn_ready;
   assign r1 = ~v1_ff | r2;
   assign up_ready  = r1;
   assign out_valid = v2_ff;
   assign out_data  = data_ff;

   always_comb begin
      xx_full = in_data.accel_x * in_data.accel_x;
      zz_full = in_data.accel_z * in_data.accel_z;
      xx_in   = xx_full[arl_pkg::SQ_W-1:0];
      zz_in   = zz_full[arl_pkg::SQ_W-1:0];
      side_in.accel_x = in_data.accel_x;
      side_in.ay      = in_data.accel_y[arl_pkg::IN_W-1] ? arl_pkg::IN_W'(-in_data.accel_y)
                                                         : arl_pkg::IN_W'(in_data.accel_y);
      side_in.yneg    = in_data.accel_y[arl_pkg::IN_W-1];
      side_in.yzero   = (in_data.accel_y == '0);
      v1_in = r1 ? in_valid : v1_ff;
   end

   always_comb begin
      sum = arl_pkg::SUM_W'(xx_ff) + arl_pkg::SUM_W'(zz_ff);
      data_in.rad  = {sum, {arl_pkg::FRAC_PAD{1'b0}}};
      data_in.rem  = '0;
      data_in.root = '0;
      data_in.side = side_ff;
      v2_in = r2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && r1) begin
         xx_ff   <= xx_in;
         zz_ff   <= zz_in;
         side_ff <= side_in;
      end
      if (v1_ff && r2) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/arl_sqrt_cell.sv =====
// -----------------------------------------------------------------------------
// arl_sqrt_cell
// One digit of the restoring integer square root: one root bit per cell.
// -----------------------------------------------------------------------------
module arl_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  arl_pkg::sqrt_type in_data,
   output logic              up_ready,
   output logic              out_valid,
   output arl_pkg::sqrt_type out_data,
   input  logic              dn_ready
);

   logic                        valid_ff, valid_in;
   arl_pkg::sqrt_type           data_ff, data_in;
   logic [arl_pkg::REM_W+1:0]   rem2, trial;

   assign up_ready  = ~valid_ff | dn_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // bring down the next two radicand bits
      rem2  = {in_data.rem, in_data.rad[arl_pkg::RAD_W-1 -: 2]};
      trial = (arl_pkg::REM_W+2)'({in_data.root, 2'b01});
      data_in      = in_data;
      data_in.rad  = in_data.rad << 2;
      if (rem2 >= trial) begin
         data_in.rem  = arl_pkg::REM_W'(rem2 - trial);
         data_in.root = {in_data.root[arl_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = arl_pkg::REM_W'(rem2);
         data_in.root = {in_data.root[arl_pkg::ROOT_W-2:0], 1'b0};
      end
      valid_in = up_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/arl_cordic_cell.sv =====
// -----------------------------------------------------------------------------
// arl_cordic_cell
// One vectoring CORDIC rotation; the cell's step number sets shift and angle.
// -----------------------------------------------------------------------------
module arl_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [arl_pkg::TAB_IDX_W-1:0] step,
   input  logic                          in_valid,
   input  arl_pkg::cordic_type           in_data,
   output logic                          up_ready,
   output logic                          out_valid,
   output arl_pkg::cordic_type           out_data,
   input  logic                          dn_ready
);

   logic                           valid_ff, valid_in;
   arl_pkg::cordic_type            data_ff, data_in;
   logic signed [arl_pkg::CW-1:0]  sx, sy;
   logic signed [arl_pkg::ACC_W-1:0] ang;

   assign up_ready  = ~valid_ff | dn_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      sx  = in_data.cx >>> step;
      sy  = in_data.cy >>> step;
      ang = arl_pkg::atan_entry(step);
      data_in = in_data;
      if (!in_data.cy[arl_pkg::CW-1]) begin
         data_in.cx  = in_data.cx + sy;
         data_in.cy  = in_data.cy - sx;
         data_in.acc = in_data.acc + ang;
      end else begin
         data_in.cx  = in_data.cx - sy;
         data_in.cy  = in_data.cy + sx;
         data_in.acc = in_data.acc - ang;
      end
      valid_in = up_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/arl_back.sv =====
// -----------------------------------------------------------------------------
// arl_back
// Scales the CORDIC angle to degrees, rounds, saturates and applies sign.
// -----------------------------------------------------------------------------
module arl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  arl_pkg::cordic_type in_data,
   output logic                up_ready,
   output logic                out_valid,
   output arl_pkg::rsp_type    out_data,
   input  logic                dn_ready
);

   logic                          v1_ff, v1_in, r1;
   logic                          v2_ff, v2_in, r2;
   logic                          v3_ff, v3_in, r3;
   logic [arl_pkg::MAG_W-1:0]     mag_ff, mag_in;
   logic                          neg1_ff, rz1_ff, neg2_ff, rz2_ff;
   arl_pkg::side_type             side1_ff, side2_ff;
   logic [arl_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [arl_pkg::PROD_W:0]      rnd;
   logic [arl_pkg::DEG_W-1:0]     deg;
   arl_pkg::rsp_type              data_ff, data_in;

   assign r3 = ~v3_ff | dn_ready;
   assign r2 = ~v2_ff | r3;
   assign r1 = ~v1_ff | r2;
   assign up_ready  = r1;
   assign out_valid = v3_ff;
   assign out_data  = data_ff;

   always_comb begin
      mag_in = in_data.acc[arl_pkg::ACC_W-1] ? arl_pkg::MAG_W'(-in_data.acc)
                                             : arl_pkg::MAG_W'(in_data.acc);
      prod_in = arl_pkg::PROD_W'(mag_ff) * arl_pkg::PROD_W'(arl_pkg::DEG_SCALE);
      v1_in = r1 ? in_valid : v1_ff;
      v2_in = r2 ? v1_ff : v2_ff;
      v3_in = r3 ? v2_ff : v3_ff;
   end

   always_comb begin
      rnd = (arl_pkg::PROD_W+1)'(prod_ff)
          + ((arl_pkg::PROD_W+1)'(1) << (arl_pkg::DEG_SHIFT-1));
      deg = rnd[arl_pkg::DEG_SHIFT +: arl_pkg::DEG_W];
      // a negative angle clamps to zero
      if (neg2_ff) begin
         deg = '0;
      end else if (deg > arl_pkg::DEG_MAX) begin
         deg = arl_pkg::DEG_MAX;
      end
      if (side2_ff.yzero) begin
         deg = '0;
      end else if (rz2_ff) begin
         deg = arl_pkg::DEG_MAX;
      end
      data_in.roll_degrees = side2_ff.yneg ? $signed(-deg) : $signed(deg);
      data_in.roll_accel   = side2_ff.accel_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && r1) begin
         mag_ff   <= mag_in;
         neg1_ff  <= in_data.acc[arl_pkg::ACC_W-1];
         rz1_ff   <= in_data.rzero;
         side1_ff <= in_data.side;
      end
      if (v1_ff && r2) begin
         prod_ff  <= prod_in;
         neg2_ff  <= neg1_ff;
         rz2_ff   <= rz1_ff;
         side2_ff <= side1_ff;
      end
      if (v2_ff && r3) begin
         data_ff <= data_in;
      end
   end

endmodule
